// File: design/tfs_pkg.sv
// Shared types, constants and helper functions for the thermal frame statistics block.
`timescale 1ns / 1ps
package tfs_pkg;

   localparam int CoordW = 17;

   localparam logic [1:0] ST_FRAME = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_SHORT = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_SAMPLE_BYTES   = 3'd2;
   localparam logic [2:0] REG_INV_SCALE      = 3'd3;
   localparam logic [2:0] REG_OFFSET_CELSIUS = 3'd4;
   localparam logic [2:0] REG_REGION_ORIGIN  = 3'd5;
   localparam logic [2:0] REG_REGION_SIZE    = 3'd6;

   localparam logic [3:0] BYTES_COUNT = 4'd2;
   localparam logic [3:0] BYTES_FLOAT = 4'd4;

   typedef struct packed {
      logic [31:0] raw_sample;
      logic        end_of_data;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pixel_temp;
      logic [1:0]         status;
      logic signed [31:0] frame_max;
      logic [9:0]         max_col;
      logic [9:0]         max_row;
      logic signed [31:0] frame_min;
      logic [9:0]         min_col;
      logic [9:0]         min_row;
      logic signed [31:0] mean_temp;
      logic signed [31:0] region_max;
      logic signed [31:0] region_min;
      logic signed [31:0] region_mean;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic temp_wr;
      logic stat_wr;
      logic div_start;
      logic div_region;
      logic mean_wr;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic last;
      logic eod;
      logic roi_ok;
      logic div_done;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] float_to_q8(input logic [31:0] bits);
      logic               neg;
      logic [7:0]         e;
      logic [23:0]        m;
      logic signed [9:0]  sh;
      logic [30:0]        v;
      logic signed [31:0] r;
      neg = bits[31];
      e = bits[30:23];
      m = {1'b0, bits[22:0]};
      v = '0;
      if (e == 8'hFF) begin
         if (m != '0) begin
            r = '0;
         end else begin
            r = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
         end
      end else begin
         if (e == 8'd0) begin
            e = 8'd1;
         end else begin
            m[23] = 1'b1;
         end
         sh = signed'({2'b00, e}) - 10'sd142;
         if (sh >= 10'sd8) begin
            r = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            if (sh >= 10'sd0) begin
               v = 31'(m) << sh[2:0];
            end else if (sh <= -10'sd24) begin
               v = '0;
            end else begin
               v = 31'(m >> 5'(-sh));
            end
            r = neg ? -signed'({1'b0, v}) : signed'({1'b0, v});
         end
      end
      return r;
   endfunction

endpackage

// File: design/tfs_div.sv
// Iterative restoring divider for the frame and region means, one quotient bit per cycle.
`timescale 1ns / 1ps
module tfs_div #(
   parameter int DW = 53
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] dividend,
   input  logic [31:0]          divisor,
   output logic                 done,
   output logic signed [31:0]   quotient
);
   localparam int CntW = $clog2(DW + 1);

   logic [DW-1:0]   a_ff, a_in;
   logic [31:0]     r_ff, r_in;
   logic [31:0]     d_ff, d_in;
   logic            neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [32:0]     trial;

   always_comb begin
      a_in = a_ff;
      r_in = r_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff, a_ff[DW-1]};
      if (start) begin
         neg_in = dividend[DW-1];
         a_in = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
         r_in = '0;
         d_in = divisor;
         cnt_in = CntW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = 32'(trial - {1'b0, d_ff});
            a_in = {a_ff[DW-2:0], 1'b1};
         end else begin
            r_in = trial[31:0];
            a_in = {a_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      r_ff <= r_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? tfs_pkg::sat32(-64'(signed'({1'b0, a_ff})))
                            : tfs_pkg::sat32(64'(signed'({1'b0, a_ff})));
endmodule

// File: design/tfs_ctrl.sv
// Controller state machine sequencing conversion, statistics update, division and output.
`timescale 1ns / 1ps
module tfs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  tfs_pkg::sts_type sts,
   output tfs_pkg::cmd_type cmd
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CONV = 4'd1;
   localparam logic [3:0] S_TEMP = 4'd2;
   localparam logic [3:0] S_STAT = 4'd3;
   localparam logic [3:0] S_FST  = 4'd4;
   localparam logic [3:0] S_DIVF = 4'd5;
   localparam logic [3:0] S_RST  = 4'd6;
   localparam logic [3:0] S_DIVR = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CONV;
            end
         end
         S_CONV: state_in = S_TEMP;
         S_TEMP: begin
            cmd.temp_wr = 1'b1;
            state_in = S_STAT;
         end
         S_STAT: begin
            cmd.stat_wr = 1'b1;
            if (sts.bad || (!sts.last && sts.eod)) begin
               cmd.clear = 1'b1;
               state_in = S_OUT;
            end else if (sts.last) begin
               state_in = S_FST;
            end else begin
               state_in = S_OUT;
            end
         end
         S_FST: begin
            cmd.div_start = 1'b1;
            state_in = S_DIVF;
         end
         S_DIVF: begin
            if (sts.div_done) begin
               cmd.mean_wr = 1'b1;
               if (sts.roi_ok) begin
                  state_in = S_RST;
               end else begin
                  cmd.clear = 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         S_RST: begin
            cmd.div_start = 1'b1;
            cmd.div_region = 1'b1;
            state_in = S_DIVR;
         end
         S_DIVR: begin
            cmd.div_region = 1'b1;
            if (sts.div_done) begin
               cmd.mean_wr = 1'b1;
               cmd.clear = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
endmodule

// File: design/tfs_datapath.sv
// Datapath: configuration registers, sample conversion, running statistics and result register.
`timescale 1ns / 1ps
module tfs_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data,
   input  tfs_pkg::req_type req_data,
   input  tfs_pkg::cmd_type cmd,
   output tfs_pkg::sts_type sts,
   output tfs_pkg::rsp_type rsp_data
);
   localparam int ColW = $clog2(MAX_WIDTH);
   localparam int RowW = $clog2(MAX_HEIGHT);
   localparam int CntW = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
   localparam int SumW = 32 + CntW;
   localparam int CW   = tfs_pkg::CoordW;

   logic [10:0]        fw_cfg_ff, fh_cfg_ff;
   logic [3:0]         bytes_ff;
   logic [31:0]        inv_ff;
   logic signed [31:0] offset_ff;
   logic [31:0]        origin_ff, size_ff;

   logic [31:0]        raw_ff;
   logic               eod_ff;
   logic signed [48:0] prod_ff;
   logic signed [31:0] flt_ff;
   logic signed [31:0] temp_ff, temp_in;

   logic [CntW-1:0]    count_ff;
   logic [ColW-1:0]    col_ff;
   logic [RowW-1:0]    row_ff;
   logic signed [31:0] max_ff, min_ff, rmax_ff, rmin_ff;
   logic [ColW-1:0]    max_col_ff, min_col_ff;
   logic [RowW-1:0]    max_row_ff, min_row_ff;
   logic signed [SumW-1:0] fsum_ff, rsum_ff;
   tfs_pkg::rsp_type   rsp_ff, rsp_in;

   logic [CW-1:0]      fw, fh, rx, ry, rw, rh, col_x, row_x;
   logic               bad, last, in_roi, roi_ok, upd_max, upd_min;
   logic               rupd_max, rupd_min;
   logic signed [48:0] adj;
   logic signed [49:0] scaled;
   logic signed [SumW-1:0] div_a;
   logic [31:0]        div_d;
   logic               div_done;
   logic signed [31:0] div_q;
   logic signed [15:0] cnt_s;
   logic signed [32:0] inv_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_cfg_ff <= 11'd384;
         fh_cfg_ff <= 11'd288;
         bytes_ff <= tfs_pkg::BYTES_COUNT;
         inv_ff <= 32'd65536;
         offset_ff <= -32'sd69926;
         origin_ff <= '0;
         size_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            tfs_pkg::REG_FRAME_WIDTH:    fw_cfg_ff <= csr_data[10:0];
            tfs_pkg::REG_FRAME_HEIGHT:   fh_cfg_ff <= csr_data[10:0];
            tfs_pkg::REG_SAMPLE_BYTES:   bytes_ff <= csr_data[3:0];
            tfs_pkg::REG_INV_SCALE:      inv_ff <= csr_data;
            tfs_pkg::REG_OFFSET_CELSIUS: offset_ff <= signed'(csr_data);
            tfs_pkg::REG_REGION_ORIGIN:  origin_ff <= csr_data;
            tfs_pkg::REG_REGION_SIZE:    size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (fw_cfg_ff == '0) fw = CW'(1);
      else if (CW'(fw_cfg_ff) > CW'(MAX_WIDTH)) fw = CW'(MAX_WIDTH);
      else fw = CW'(fw_cfg_ff);
      if (fh_cfg_ff == '0) fh = CW'(1);
      else if (CW'(fh_cfg_ff) > CW'(MAX_HEIGHT)) fh = CW'(MAX_HEIGHT);
      else fh = CW'(fh_cfg_ff);
      rx = CW'(origin_ff[15:0]);
      ry = CW'(origin_ff[31:16]);
      rw = CW'(size_ff[15:0]);
      rh = CW'(size_ff[31:16]);
      col_x = CW'(col_ff);
      row_x = CW'(row_ff);
      bad = (bytes_ff != tfs_pkg::BYTES_COUNT) && (bytes_ff != tfs_pkg::BYTES_FLOAT);
      last = (col_x + CW'(1) >= fw) && (row_x + CW'(1) >= fh);
      roi_ok = (rw != '0) && (rh != '0) && (rx + rw <= fw) && (ry + rh <= fh);
      in_roi = (col_x >= rx) && (col_x < rx + rw) && (row_x >= ry) && (row_x < ry + rh);
      upd_max = temp_ff > max_ff;
      upd_min = temp_ff < min_ff;
      rupd_max = temp_ff > rmax_ff;
      rupd_min = temp_ff < rmin_ff;
   end

   assign cnt_s = signed'(raw_ff[15:0]);
   assign inv_s = signed'({1'b0, inv_ff});

   always_comb begin
      adj = prod_ff[48] ? prod_ff + 49'sd255 : prod_ff;
      scaled = 50'(adj >>> 8) + 50'(offset_ff);
      temp_in = (bytes_ff == tfs_pkg::BYTES_COUNT) ? tfs_pkg::sat32(64'(scaled)) : flt_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= req_data.raw_sample;
         eod_ff <= req_data.end_of_data;
      end
      prod_ff <= cnt_s * inv_s;
      flt_ff <= tfs_pkg::float_to_q8(raw_ff);
      if (cmd.temp_wr) temp_ff <= temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         max_ff <= 32'sh80000000;
         min_ff <= 32'sh7FFFFFFF;
         rmax_ff <= 32'sh80000000;
         rmin_ff <= 32'sh7FFFFFFF;
         max_col_ff <= '0;
         max_row_ff <= '0;
         min_col_ff <= '0;
         min_row_ff <= '0;
         fsum_ff <= '0;
         rsum_ff <= '0;
      end else if (cmd.stat_wr && !bad) begin
         fsum_ff <= fsum_ff + SumW'(temp_ff);
         if (upd_max) begin
            max_ff <= temp_ff;
            max_col_ff <= col_ff;
            max_row_ff <= row_ff;
         end
         if (upd_min) begin
            min_ff <= temp_ff;
            min_col_ff <= col_ff;
            min_row_ff <= row_ff;
         end
         if (in_roi) begin
            rsum_ff <= rsum_ff + SumW'(temp_ff);
            if (rupd_max) rmax_ff <= temp_ff;
            if (rupd_min) rmin_ff <= temp_ff;
         end
         if (!last) begin
            count_ff <= count_ff + CntW'(1);
            if (col_x + CW'(1) >= fw) begin
               col_ff <= '0;
               row_ff <= row_ff + RowW'(1);
            end else begin
               col_ff <= col_ff + ColW'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.stat_wr) begin
         rsp_in = '0;
         if (bad) begin
            rsp_in.status = tfs_pkg::ST_BAD;
         end else begin
            rsp_in.pixel_temp = temp_ff;
            if (last) begin
               rsp_in.status = tfs_pkg::ST_DONE;
               rsp_in.frame_max = upd_max ? temp_ff : max_ff;
               rsp_in.max_col = 10'(upd_max ? col_ff : max_col_ff);
               rsp_in.max_row = 10'(upd_max ? row_ff : max_row_ff);
               rsp_in.frame_min = upd_min ? temp_ff : min_ff;
               rsp_in.min_col = 10'(upd_min ? col_ff : min_col_ff);
               rsp_in.min_row = 10'(upd_min ? row_ff : min_row_ff);
               if (roi_ok) begin
                  rsp_in.region_max = (in_roi && rupd_max) ? temp_ff : rmax_ff;
                  rsp_in.region_min = (in_roi && rupd_min) ? temp_ff : rmin_ff;
               end
            end else if (eod_ff) begin
               rsp_in.status = tfs_pkg::ST_SHORT;
            end else begin
               rsp_in.status = tfs_pkg::ST_FRAME;
            end
         end
      end else if (cmd.mean_wr) begin
         if (cmd.div_region) rsp_in.region_mean = div_q;
         else rsp_in.mean_temp = div_q;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign div_a = cmd.div_region ? rsum_ff : fsum_ff;
   assign div_d = cmd.div_region ? size_ff[15:0] * size_ff[31:16]
                                 : 32'(count_ff + CntW'(1));

   tfs_div #(.DW(SumW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sts = '{bad: bad, last: last, eod: eod_ff, roi_ok: roi_ok, div_done: div_done};
   assign rsp_data = rsp_ff;
endmodule

// File: design/thermal_frame_statistics.sv
// Top level of the thermal frame statistics block: controller, datapath and checks.
// An ordinary pixel is loaded, converted and written to the temperature and statistics
// registers before its result is offered; the next input is taken only after that result
// has been accepted, one item at a time. The last pixel of a frame adds one divider pass
// for the frame mean and, with a valid region, a second pass for the region mean.
// Synchronous active-high reset restores register defaults and clears all frame statistics.
`timescale 1ns / 1ps
module thermal_frame_statistics #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tfs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);
   tfs_pkg::cmd_type cmd;
   tfs_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   tfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tfs_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

   a_no_take_while_holding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while a result waits");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid) else $error("result without processing");

   a_stats_zero_unless_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != tfs_pkg::ST_DONE) |->
      (rsp_data.frame_max == 0 && rsp_data.mean_temp == 0 && rsp_data.region_mean == 0))
      else $error("statistics set on a result that is not frame done");

   a_bad_zero_temp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == tfs_pkg::ST_BAD) |-> rsp_data.pixel_temp == 0)
      else $error("bad sample size result carries a temperature");
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the thermal frame statistics block.
`timescale 1ns / 1ps
module tb_top;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tfs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tfs_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = '0;
   logic [31:0]      csr_data = '0;

   thermal_frame_statistics dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   tfs_pkg::req_type pixel_q[$];
   tfs_pkg::rsp_type temp_q[$];
   int      errors = 0;
   int      pixels_queued = 0;

   logic [10:0]        cfg_width = 11'd384;
   logic [10:0]        cfg_height = 11'd288;
   logic [3:0]         cfg_bytes = tfs_pkg::BYTES_COUNT;
   logic [31:0]        cfg_inv_scale = 32'd65536;
   logic signed [31:0] cfg_offset = -32'sd69926;
   logic [31:0]        cfg_origin = '0;
   logic [31:0]        cfg_size = '0;

   longint             px_count, col, row, sum_all, sum_roi;
   logic signed [31:0] hot, cold, roi_hot, roi_cold;
   logic [9:0]         hot_col, hot_row, cold_col, cold_row;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL thermal_frame_statistics");
      $finish;
   end

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] count_to_q8(logic [31:0] raw);
      longint c, scaled;
      c = longint'($signed(raw[15:0]));
      scaled = (c * longint'({32'd0, cfg_inv_scale})) / 256;
      return clamp32(scaled + longint'(cfg_offset));
   endfunction

   function automatic logic signed [31:0] float_bits_to_q8(logic [31:0] bits);
      longint e, m, sh, v;
      e = bits[30:23];
      m = bits[22:0];
      if (e == 255) begin
         if (m != 0) return 0;
         return bits[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
      if (e == 0) e = 1;
      else m = m | 64'h800000;
      sh = e - 142;
      if (sh >= 8) return bits[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
      if (sh >= 0) v = m << sh;
      else if (-sh >= 24) v = 0;
      else v = m >> (-sh);
      return bits[31] ? clamp32(-v) : clamp32(v);
   endfunction

   function automatic void clear_stats();
      px_count = 0; col = 0; row = 0; sum_all = 0; sum_roi = 0;
      hot = 32'sh80000000; hot_col = '0; hot_row = '0;
      cold = 32'sh7FFFFFFF; cold_col = '0; cold_row = '0;
      roi_hot = 32'sh80000000; roi_cold = 32'sh7FFFFFFF;
   endfunction

   function automatic tfs_pkg::rsp_type thermal_predict(tfs_pkg::req_type r);
      tfs_pkg::rsp_type   o;
      longint             fw, fh, rx, ry, rw, rh;
      logic signed [31:0] t;
      bit                 roi_ok;
      o = '0;
      fw = cfg_width; fh = cfg_height;
      if (fw < 1) fw = 1;
      if (fw > 1024) fw = 1024;
      if (fh < 1) fh = 1;
      if (fh > 1024) fh = 1024;
      rx = cfg_origin[15:0]; ry = cfg_origin[31:16];
      rw = cfg_size[15:0]; rh = cfg_size[31:16];
      if (cfg_bytes != tfs_pkg::BYTES_COUNT && cfg_bytes != tfs_pkg::BYTES_FLOAT) begin
         o.status = tfs_pkg::ST_BAD;
         clear_stats();
         return o;
      end
      t = (cfg_bytes == tfs_pkg::BYTES_COUNT) ? count_to_q8(r.raw_sample)
                                              : float_bits_to_q8(r.raw_sample);
      o.pixel_temp = t;
      sum_all += longint'(t);
      if (t > hot) begin hot = t; hot_col = col[9:0]; hot_row = row[9:0]; end
      if (t < cold) begin cold = t; cold_col = col[9:0]; cold_row = row[9:0]; end
      roi_ok = rw > 0 && rh > 0 && rx + rw <= fw && ry + rh <= fh;
      if (col >= rx && col < rx + rw && row >= ry && row < ry + rh) begin
         sum_roi += longint'(t);
         if (t > roi_hot) roi_hot = t;
         if (t < roi_cold) roi_cold = t;
      end
      if (col + 1 >= fw && row + 1 >= fh) begin
         o.status = tfs_pkg::ST_DONE;
         o.frame_max = hot; o.max_col = hot_col; o.max_row = hot_row;
         o.frame_min = cold; o.min_col = cold_col; o.min_row = cold_row;
         o.mean_temp = clamp32(sum_all / (px_count + 1));
         if (roi_ok) begin
            o.region_max = roi_hot;
            o.region_min = roi_cold;
            o.region_mean = clamp32(sum_roi / (rw * rh));
         end
         clear_stats();
         return o;
      end
      if (r.end_of_data) begin
         o.status = tfs_pkg::ST_SHORT;
         clear_stats();
         return o;
      end
      px_count++;
      if (col + 1 >= fw) begin col = 0; row++; end
      else col++;
      return o;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
   endfunction

   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            temp_q = {temp_q, thermal_predict(req_data)};
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pixel_q.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   int stall_mode = 0;
   int stall_timer = 0;

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode = $urandom % 4;
         stall_timer = $urandom_range(10, 80);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom % 2);
         2: rsp_stall <= ($urandom % 5) != 0;
         default: rsp_stall <= stall_timer[2];
      endcase
   end

   always @(posedge clock) begin
      tfs_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (temp_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got status %0d",
                     $time, rsp_data.status);
         end else begin
            e = temp_q.pop_front();
            check_field("pixel_temp", e.pixel_temp, rsp_data.pixel_temp);
            check_field("status", e.status, rsp_data.status);
            check_field("frame_max", e.frame_max, rsp_data.frame_max);
            check_field("max_col", e.max_col, rsp_data.max_col);
            check_field("max_row", e.max_row, rsp_data.max_row);
            check_field("frame_min", e.frame_min, rsp_data.frame_min);
            check_field("min_col", e.min_col, rsp_data.min_col);
            check_field("min_row", e.min_row, rsp_data.min_row);
            check_field("mean_temp", e.mean_temp, rsp_data.mean_temp);
            check_field("region_max", e.region_max, rsp_data.region_max);
            check_field("region_min", e.region_min, rsp_data.region_min);
            check_field("region_mean", e.region_mean, rsp_data.region_mean);
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         tfs_pkg::REG_FRAME_WIDTH:    cfg_width = value[10:0];
         tfs_pkg::REG_FRAME_HEIGHT:   cfg_height = value[10:0];
         tfs_pkg::REG_SAMPLE_BYTES:   cfg_bytes = value[3:0];
         tfs_pkg::REG_INV_SCALE:      cfg_inv_scale = value;
         tfs_pkg::REG_OFFSET_CELSIUS: cfg_offset = value;
         tfs_pkg::REG_REGION_ORIGIN:  cfg_origin = value;
         tfs_pkg::REG_REGION_SIZE:    cfg_size = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pixel_q.size() != 0 || temp_q.size() != 0 || req_valid) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic push_pixel(logic [31:0] raw, logic eod);
      tfs_pkg::req_type r;
      r.raw_sample = raw;
      r.end_of_data = eod;
      pixel_q = {pixel_q, r};
      pixels_queued++;
   endtask

   function automatic logic [31:0] make_raw(bit flt);
      logic [31:0] v;
      v = $urandom;
      if (flt) begin
         case ($urandom % 5) inside
            0: ;
            1, 2: v[30:23] = 8'($urandom_range(118, 152));
            3: v[30:23] = 8'($urandom_range(0, 5));
            default: v[30:23] = ($urandom % 2) ? 8'hFF : 8'd150;
         endcase
      end
      return v;
   endfunction

   task automatic queue_frames(int nframes);
      int fw, fh, n, cut;
      fw = cfg_width; fh = cfg_height;
      if (fw < 1) fw = 1;
      if (fw > 1024) fw = 1024;
      if (fh < 1) fh = 1;
      if (fh > 1024) fh = 1024;
      for (int f = 0; f < nframes; f++) begin
         n = fw * fh;
         cut = ($urandom % 8 == 0 && n > 1) ? $urandom_range(0, n - 2) : n;
         for (int i = 0; i < n && i <= cut; i++) begin
            push_pixel(make_raw(cfg_bytes == tfs_pkg::BYTES_FLOAT),
                       (i == cut) ? 1'b1 : (i == n - 1) ? 1'($urandom % 2) : 1'b0);
         end
         if ($urandom % 10 == 0) push_pixel($urandom, 1'($urandom % 2));
      end
   endtask

   task automatic set_geometry(logic [10:0] w, logic [10:0] h, logic [3:0] b);
      csr_write(tfs_pkg::REG_FRAME_WIDTH, 32'(w));
      csr_write(tfs_pkg::REG_FRAME_HEIGHT, 32'(h));
      csr_write(tfs_pkg::REG_SAMPLE_BYTES, 32'(b));
   endtask

   initial begin
      int          fw, fh, rw, rh;
      logic [31:0] scales[4];
      logic [31:0] specials[8];
      clear_stats();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_geometry(11'd4, 11'd2, tfs_pkg::BYTES_COUNT);
      csr_write(tfs_pkg::REG_INV_SCALE, 32'd65536);
      csr_write(tfs_pkg::REG_OFFSET_CELSIUS, -32'sd69926);
      csr_write(tfs_pkg::REG_REGION_ORIGIN, {16'd0, 16'd1});
      csr_write(tfs_pkg::REG_REGION_SIZE, {16'd2, 16'd2});
      push_pixel(32'h00007FFF, 1'b0);
      push_pixel(32'h00008000, 1'b0);
      push_pixel(32'hFFFF0000, 1'b0);
      push_pixel(32'h00000001, 1'b0);
      push_pixel(32'h0000FFFF, 1'b0);
      push_pixel(32'h12340064, 1'b0);
      push_pixel(32'hABCDFF9C, 1'b0);
      push_pixel(32'h00007FFF, 1'b1);
      drain();
      csr_write(tfs_pkg::REG_SAMPLE_BYTES, 32'(tfs_pkg::BYTES_FLOAT));
      specials = '{32'h7FC00000, 32'h7F800000, 32'hFF800000, 32'h4F000000,
                   32'h00000001, 32'h3FC00000, 32'hC0100000, 32'h80000000};
      foreach (specials[i]) push_pixel(specials[i], 1'(i == 7));
      push_pixel(32'h42280000, 1'b0);
      push_pixel(32'hC2280000, 1'b1);
      drain();
      csr_write(tfs_pkg::REG_SAMPLE_BYTES, 32'd3);
      push_pixel(32'h00001234, 1'b0);
      drain();
      csr_write(tfs_pkg::REG_SAMPLE_BYTES, 32'd0);
      push_pixel(32'hFFFFFFFF, 1'b1);
      drain();
      csr_write(tfs_pkg::REG_SAMPLE_BYTES, 32'd15);
      push_pixel(32'h00000000, 1'b0);
      drain();

      scales = '{32'd0, 32'hFFFFFFFF, 32'd65536, 32'd1};
      while (pixels_queued < 300) begin
         drain();
         set_geometry(11'($urandom_range(0, 9)), 11'($urandom_range(0, 6)),
                      ($urandom % 10 == 0) ? 4'($urandom_range(0, 15))
                      : (($urandom % 2) ? tfs_pkg::BYTES_COUNT : tfs_pkg::BYTES_FLOAT));
         if ($urandom % 2)
            csr_write(tfs_pkg::REG_INV_SCALE,
                      ($urandom % 2) ? scales[$urandom % 4] : $urandom);
         if ($urandom % 2) begin
            case ($urandom % 4)
               0: csr_write(tfs_pkg::REG_OFFSET_CELSIUS, 32'h7FFFFFFF);
               1: csr_write(tfs_pkg::REG_OFFSET_CELSIUS, 32'h80000000);
               default: csr_write(tfs_pkg::REG_OFFSET_CELSIUS, $urandom);
            endcase
         end
         fw = (cfg_width < 1) ? 1 : cfg_width;
         fh = (cfg_height < 1) ? 1 : cfg_height;
         if ($urandom % 4 != 0) begin
            rw = $urandom_range(1, fw);
            rh = $urandom_range(1, fh);
            csr_write(tfs_pkg::REG_REGION_SIZE, {16'(rh), 16'(rw)});
            csr_write(tfs_pkg::REG_REGION_ORIGIN,
                      {16'($urandom_range(0, fh - rh)), 16'($urandom_range(0, fw - rw))});
         end else begin
            csr_write(tfs_pkg::REG_REGION_SIZE,
                      ($urandom % 2) ? $urandom : {16'(fh), 16'd0});
            csr_write(tfs_pkg::REG_REGION_ORIGIN,
                      ($urandom % 2) ? $urandom : {16'd0, 16'd1});
         end
         queue_frames($urandom_range(1, 6));
      end

      drain();
      set_geometry(11'd2047, 11'd1, tfs_pkg::BYTES_COUNT);
      csr_write(tfs_pkg::REG_REGION_ORIGIN, {16'd0, 16'd1000});
      csr_write(tfs_pkg::REG_REGION_SIZE, {16'd1, 16'd24});
      queue_frames(1);

      drain();
      repeat (300) @(posedge clock);
      if (errors == 0 && temp_q.size() == 0) begin
         $display("PASS thermal_frame_statistics");
      end else begin
         $display("FAIL thermal_frame_statistics");
      end
      $finish;
   end

endmodule
